@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/stb_pkg.sv @@
package stb_pkg;

    // bank geometry
    localparam int NUM_SLOTS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int MAX_OUT    = 16;

    localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OUT_BITS   = $clog2(MAX_OUT + 1);

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_DISARM = 2'd2
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // contents of one timer cell
    typedef struct packed {
        logic                  armed;
        logic [COUNT_BITS-1:0] remaining;
        logic [COUNT_BITS-1:0] reload;
    } t_cell;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic arm;
        logic disarm;
    } t_cell_ctl;

    // mask a 16-bit count word to the count width
    function automatic logic [COUNT_BITS-1:0] to_count(input logic [15:0] v);
        logic [COUNT_BITS+15:0] ext;
        ext = {{COUNT_BITS{1'b0}}, v};
        return ext[COUNT_BITS-1:0];
    endfunction

    // low four bits of a slot index
    function automatic logic [3:0] to_fired(input logic [SLOT_BITS-1:0] k);
        logic [SLOT_BITS+3:0] ext;
        ext = {4'b0000, k};
        return ext[3:0];
    endfunction

endpackage

@@ rtl/stb_cell.sv @@
module stb_cell
    import stb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell     i_load,
    input  t_cell     i_prev,
    output t_cell     o_cell
);

    logic                  r_armed;
    logic [COUNT_BITS-1:0] r_remaining;
    logic [COUNT_BITS-1:0] r_reload;

    // armed flag: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_ctl.shift) begin
            r_armed <= i_prev.armed;
        end else if (i_ctl.arm) begin
            r_armed <= 1'b1;
        end else if (i_ctl.disarm) begin
            r_armed <= 1'b0;
        end
    end

    // counts: shift from neighbor or load on arm
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_remaining <= i_prev.remaining;
            r_reload    <= i_prev.reload;
        end else if (i_ctl.arm) begin
            r_remaining <= i_load.remaining;
            r_reload    <= i_load.reload;
        end
    end

    assign o_cell = '{armed: r_armed, remaining: r_remaining, reload: r_reload};

endmodule

@@ rtl/stb_head.sv @@
module stb_head
    import stb_pkg::*;
(
    input  t_cell i_cell,
    output t_cell o_cell,
    output logic  o_fire
);

    // count down, or expire and reload / disarm
    always_comb begin
        o_cell = i_cell;
        o_fire = 1'b0;
        if (i_cell.armed) begin
            if (i_cell.remaining != '0) begin
                o_cell.remaining = i_cell.remaining - 1'b1;
            end else begin
                o_fire = 1'b1;
                if (i_cell.reload != '0) begin
                    o_cell.remaining = i_cell.reload;
                end else begin
                    o_cell.armed = 1'b0;
                end
            end
        end
    end

endmodule

@@ rtl/software_timer_bank.sv @@
// channel   | signals                                            | dir
// command   | start, i_kind, i_slot, i_start_count,              | in
//           | i_reload_count (busy is an output)                 |
// expiry    | o_valid, o_fired_slot, o_last                      | out
//
// a tick rotates the ring of slot cells once,
//   one slot through the head unit per cycle, then a flush state ends the tick
// arm and disarm write their cell directly; busy stays low
// expiries strobe in slot order, each the cycle after the next one (or the flush) is seen
// reset (i_rst_n low, synchronous) disarms every slot and idles the sequencer
// the receiver cannot stall: each strobe is a one-cycle word
`include "assert_macros.svh"

module software_timer_bank
    import stb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_start_count,
    input  logic [15:0] i_reload_count,
    output logic        o_valid,
    output logic [3:0]  o_fired_slot,
    output logic        o_last
);

    localparam logic [SLOT_BITS-1:0] LAST_STEP = SLOT_BITS'(NUM_SLOTS - 1);
    localparam logic [6:0]           SLOTS_W   = 7'(NUM_SLOTS);

    t_state               r_state, n_state;
    logic [SLOT_BITS-1:0] r_step, n_step;
    logic                 r_pend_v, n_pend_v;
    logic [3:0]           r_pend_slot, n_pend_slot;
    logic [OUT_BITS-1:0]  r_n_out, n_n_out;
    logic                 r_valid, n_valid;
    logic [3:0]           r_fired, n_fired;
    logic                 r_last, n_last;

    logic   accept;
    logic   slot_ok;
    logic   do_shift;
    logic   fire;
    t_cell  load_word;
    t_cell  head_next;
    t_cell  cells [NUM_SLOTS];

    assign accept  = start && !busy;
    assign slot_ok = {3'b000, i_slot} < SLOTS_W;
    assign load_word = '{armed: 1'b1, remaining: to_count(i_start_count),
                         reload: to_count(i_reload_count)};

    // ring of slot cells; slot 0 sits at the head
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        t_cell_ctl ctl;
        t_cell     prev;

        assign ctl.shift  = do_shift;
        assign ctl.arm    = accept && (t_kind'(i_kind) == KIND_ARM) && slot_ok
                            && ({3'b000, i_slot} == 7'(i));
        assign ctl.disarm = accept && (t_kind'(i_kind) == KIND_DISARM) && slot_ok
                            && ({3'b000, i_slot} == 7'(i));

        if (i == NUM_SLOTS - 1) begin : g_tail
            assign prev = head_next;
        end else begin : g_mid
            assign prev = cells[i+1];
        end

        stb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_load  (load_word),
            .i_prev  (prev),
            .o_cell  (cells[i])
        );
    end

    // update unit at the head of the ring
    stb_head u_head (
        .i_cell (cells[0]),
        .o_cell (head_next),
        .o_fire (fire)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_pend_v <= 1'b0;
            r_n_out  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_pend_v <= n_pend_v;
            r_n_out  <= n_n_out;
            r_valid  <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_fired     <= n_fired;
        r_last      <= n_last;
    end

    // next state; an expiry is held until the next one, or the flush, shows whether it is last
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_n_out     = r_n_out;
        n_valid     = 1'b0;
        n_fired     = r_fired;
        n_last      = 1'b0;
        do_shift    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (t_kind'(i_kind) == KIND_TICK)) begin
                    n_state  = ST_RUN;
                    n_step   = '0;
                    n_n_out  = '0;
                    n_pend_v = 1'b0;
                end
            end
            ST_RUN: begin
                do_shift = 1'b1;
                if (fire && (r_n_out < OUT_BITS'(MAX_OUT))) begin
                    if (r_pend_v) begin
                        n_valid = 1'b1;
                        n_fired = r_pend_slot;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_slot = to_fired(r_step);
                    n_n_out     = r_n_out + 1'b1;
                end
                if (r_step == LAST_STEP) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v) begin
                    n_valid = 1'b1;
                    n_fired = r_pend_slot;
                    n_last  = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_fired_slot = r_fired;
    assign o_last       = r_last && r_valid;

    // checks
    `ASSERT_NEXT(a_word_only_from_tick, i_clk, i_rst_n, r_state == ST_IDLE && !accept, !o_valid)
    `ASSERT_NEXT(a_flush_ends_tick, i_clk, i_rst_n, r_state == ST_FLUSH, r_state == ST_IDLE)
    `ASSERT_IMPLIES(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_v)
    `ASSERT_IMPLIES(a_count_bounded, i_clk, i_rst_n, 1'b1, r_n_out <= OUT_BITS'(MAX_OUT))

endmodule
